>>> sv/rgbwlm_pkg.sv
// Shared types, constants and helper functions for the RGB to RGBW light mapper.
package rgbwlm_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SUM_W   = 10;
  localparam int unsigned LEVEL_W = 10;

  typedef enum logic [1:0] {
    CFG_DARK_SUM_LIMIT = 2'd0,
    CFG_GREY_TOLERANCE = 2'd1,
    CFG_GREY_MIN_SUM   = 2'd2,
    CFG_HUE_TOLERANCE  = 2'd3
  } cfg_idx_t;

  localparam logic [SUM_W-1:0]  DARK_SUM_LIMIT_RST = 10'd150;
  localparam logic [CHAN_W-1:0] GREY_TOLERANCE_RST = 8'd13;
  localparam logic [SUM_W-1:0]  GREY_MIN_SUM_RST   = 10'd254;
  localparam logic [CHAN_W-1:0] HUE_TOLERANCE_RST  = 8'd10;

  localparam logic [CHAN_W-1:0]         FULL_LEVEL     = 8'd255;
  localparam logic [CHAN_W-1:0]         BRIGHT_GREEN   = 8'd200;
  localparam logic signed [LEVEL_W-1:0] BLUE_CUT_HIGH  = 10'sd150;
  localparam logic signed [LEVEL_W-1:0] BLUE_CUT_LOW   = 10'sd120;
  localparam logic signed [LEVEL_W-1:0] RED_CUT_GREEN  = 10'sd100;
  localparam logic signed [LEVEL_W-1:0] GREEN_BOOST    = 10'sd100;
  localparam logic signed [LEVEL_W-1:0] RED_CUT_BLUE   = 10'sd50;
  localparam logic signed [LEVEL_W-1:0] FLOOR_LEVEL    = 10'sd5;

  // floor(x/3) as x*683 >> 11, exact for x up to 765
  localparam logic [SUM_W:0] DIV3_MUL   = 11'd683;
  localparam int unsigned    DIV3_SHIFT = 11;

  typedef struct packed {
    logic [SUM_W-1:0]  dark_sum_limit;
    logic [CHAN_W-1:0] grey_tolerance;
    logic [SUM_W-1:0]  grey_min_sum;
    logic [CHAN_W-1:0] hue_tolerance;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              front_en;
    logic              back_en;
  } colour_t;

  typedef struct packed {
    logic [CHAN_W-1:0] front_red;
    logic [CHAN_W-1:0] front_green;
    logic [CHAN_W-1:0] front_blue;
    logic [CHAN_W-1:0] front_white;
    logic [CHAN_W-1:0] rear_red;
    logic [CHAN_W-1:0] rear_green;
    logic [CHAN_W-1:0] rear_blue;
    logic [CHAN_W-1:0] rear_white;
    logic [CHAN_W-1:0] master_level;
  } lamps_t;

  function automatic logic [CHAN_W-1:0] clamp8(input logic signed [LEVEL_W-1:0] v);
    logic [CHAN_W-1:0] res;
    if (v <= 10'sd0) begin
      res = '0;
    end else if (v >= 10'sd255) begin
      res = FULL_LEVEL;
    end else begin
      res = v[CHAN_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [CHAN_W-1:0] absdiff8(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CHAN_W-1:0] div3(input logic [SUM_W-1:0] x);
    logic [2*SUM_W:0] prod;
    prod = {{(SUM_W+1){1'b0}}, x} * {{SUM_W{1'b0}}, DIV3_MUL};
    return prod[DIV3_SHIFT +: CHAN_W];
  endfunction

endpackage

>>> sv/rgbwlm_map.sv
// Combinational colour classification and RGBW lamp level mapping.
module rgbwlm_map (
  input  rgbwlm_pkg::colour_t colour,
  input  rgbwlm_pkg::cfg_t    cfg,
  output rgbwlm_pkg::lamps_t  lamps
);
  import rgbwlm_pkg::*;

  logic [CHAN_W-1:0]         r0, g0, b0;
  logic [SUM_W-1:0]          sum;
  logic [CHAN_W-1:0]         d_rg, d_gb, d_rb;
  logic signed [LEVEL_W-1:0] sr, sg, sb;
  logic signed [LEVEL_W-1:0] lr, lg, lb, lw;
  logic [CHAN_W-1:0]         cr, cg, cb, cw;

  assign r0   = colour.red;
  assign g0   = colour.green;
  assign b0   = colour.blue;
  assign sum  = SUM_W'(r0) + SUM_W'(g0) + SUM_W'(b0);
  assign d_rg = absdiff8(r0, g0);
  assign d_gb = absdiff8(g0, b0);
  assign d_rb = absdiff8(r0, b0);
  assign sr   = $signed({2'b00, r0});
  assign sg   = $signed({2'b00, g0});
  assign sb   = $signed({2'b00, b0});

  // first matching rule wins
  always_comb begin
    lr = sr;
    lg = sg;
    lb = sb;
    lw = '0;
    if (sum < cfg.dark_sum_limit) begin
      lr = '0;
      lg = '0;
      lb = '0;
    end else if (d_rg < cfg.grey_tolerance && d_gb < cfg.grey_tolerance &&
                 sum > cfg.grey_min_sum) begin
      lr = '0;
      lg = '0;
      lb = '0;
      lw = $signed({2'b00, FULL_LEVEL});
    end else if (d_gb < cfg.hue_tolerance && r0 > g0 && r0 > b0) begin
      lw = sg;
      lg = '0;
      lb = '0;
    end else if (d_gb < cfg.hue_tolerance && r0 < g0 && r0 < b0) begin
      lw = sr;
      lr = '0;
    end else if (d_rb < cfg.hue_tolerance && g0 > r0 && g0 > b0) begin
      lw = sr;
      lr = '0;
      lb = '0;
    end else if (d_rb < cfg.hue_tolerance && g0 < r0 && g0 < b0) begin
      lw = sg;
      lg = '0;
    end else if (d_rg < cfg.hue_tolerance && b0 > g0 && b0 > r0) begin
      lw = sg;
      lr = '0;
      lg = '0;
    end else if (d_rg < cfg.hue_tolerance && b0 < r0 && b0 < g0) begin
      lw = sb;
      lb = '0;
    end else if (b0 >= r0 && g0 >= r0) begin
      if (g0 >= b0) begin
        lb = sb - ((g0 > BRIGHT_GREEN) ? BLUE_CUT_HIGH : BLUE_CUT_LOW);
      end
      lw = sr;
      lr = '0;
    end else if (r0 >= g0 && b0 >= g0) begin
      if (b0 >= r0) begin
        lr = sr - RED_CUT_GREEN;
      end
      lw = sg;
      lg = FLOOR_LEVEL;
    end else begin
      if (g0 >= r0) begin
        lg = sg + GREEN_BOOST;
        lr = sr - RED_CUT_BLUE;
      end
      lw = sb;
      lb = FLOOR_LEVEL;
    end
  end

  assign cr = clamp8(lr);
  assign cg = clamp8(lg);
  assign cb = clamp8(lb);
  assign cw = clamp8(lw);

  assign lamps.front_red    = colour.front_en ? cr : '0;
  assign lamps.front_green  = colour.front_en ? cg : '0;
  assign lamps.front_blue   = colour.front_en ? cb : '0;
  assign lamps.front_white  = colour.front_en ? cw : '0;
  assign lamps.rear_red     = colour.back_en ? cr : '0;
  assign lamps.rear_green   = colour.back_en ? cg : '0;
  assign lamps.rear_blue    = colour.back_en ? cb : '0;
  assign lamps.rear_white   = colour.back_en ? cw : '0;
  assign lamps.master_level = div3(sum);

endmodule

>>> sv/rgb_to_rgbw_light_mapper_top.sv
// Top level of the RGB to RGBW light mapper: input register, mapping, result register.
//
//   port group | dir | handshake           | word
//   in_*       | in  | in_valid / in_stall  | averaged colour and two fixture enables
//   out_*      | out | out_valid / out_stall| eight lamp levels and master level
//   cfg_*      | in  | cfg_we               | register write, no read-back
//
// One word per cycle sustained while out_stall is low.
// The mapping sits between the input register and the result register.
// rst_n (synchronous) empties both stages and loads register defaults.
// A stalled result holds; the input register still fills behind it, then in_stall rises.
module rgb_to_rgbw_light_mapper_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rgbwlm_pkg::CHAN_W-1:0]   in_red_in,
  input  logic [rgbwlm_pkg::CHAN_W-1:0]   in_green_in,
  input  logic [rgbwlm_pkg::CHAN_W-1:0]   in_blue_in,
  input  logic                            in_front_enable,
  input  logic                            in_back_enable,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rgbwlm_pkg::CHAN_W-1:0]   out_front_red,
  output logic [rgbwlm_pkg::CHAN_W-1:0]   out_front_green,
  output logic [rgbwlm_pkg::CHAN_W-1:0]   out_front_blue,
  output logic [rgbwlm_pkg::CHAN_W-1:0]   out_front_white,
  output logic [rgbwlm_pkg::CHAN_W-1:0]   out_rear_red,
  output logic [rgbwlm_pkg::CHAN_W-1:0]   out_rear_green,
  output logic [rgbwlm_pkg::CHAN_W-1:0]   out_rear_blue,
  output logic [rgbwlm_pkg::CHAN_W-1:0]   out_rear_white,
  output logic [rgbwlm_pkg::CHAN_W-1:0]   out_master_level,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [rgbwlm_pkg::SUM_W-1:0]    cfg_wdata
);
  import rgbwlm_pkg::*;

  cfg_t    cfg_r;
  colour_t in_word_r;
  colour_t in_word_nxt;
  logic    in_valid_r;
  lamps_t  lamps;
  lamps_t  out_word_r;
  logic    out_valid_r;
  logic    in_take;
  logic    in_move;
  logic    out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_move  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign in_word_nxt = '{red: in_red_in, green: in_green_in, blue: in_blue_in,
                         front_en: in_front_enable, back_en: in_back_enable};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dark_sum_limit <= DARK_SUM_LIMIT_RST;
      cfg_r.grey_tolerance <= GREY_TOLERANCE_RST;
      cfg_r.grey_min_sum   <= GREY_MIN_SUM_RST;
      cfg_r.hue_tolerance  <= HUE_TOLERANCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DARK_SUM_LIMIT: cfg_r.dark_sum_limit <= cfg_wdata;
        CFG_GREY_TOLERANCE: cfg_r.grey_tolerance <= cfg_wdata[CHAN_W-1:0];
        CFG_GREY_MIN_SUM:   cfg_r.grey_min_sum   <= cfg_wdata;
        CFG_HUE_TOLERANCE:  cfg_r.hue_tolerance  <= cfg_wdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (in_move) begin
        in_valid_r <= 1'b0;
      end
      if (in_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_word_nxt;
    end
    if (in_move) begin
      out_word_r <= lamps;
    end
  end

  rgbwlm_map u_map (
    .colour (in_word_r),
    .cfg    (cfg_r),
    .lamps  (lamps)
  );

  assign out_valid        = out_valid_r;
  assign out_front_red    = out_word_r.front_red;
  assign out_front_green  = out_word_r.front_green;
  assign out_front_blue   = out_word_r.front_blue;
  assign out_front_white  = out_word_r.front_white;
  assign out_rear_red     = out_word_r.rear_red;
  assign out_rear_green   = out_word_r.rear_green;
  assign out_rear_blue    = out_word_r.rear_blue;
  assign out_rear_white   = out_word_r.rear_white;
  assign out_master_level = out_word_r.master_level;

endmodule

>>> sv/rgbwlm_checker.sv
// Port-level checks for the RGB to RGBW light mapper, bound to the top level.
module rgbwlm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rgbwlm_pkg::CHAN_W-1:0] out_front_white,
  input logic [rgbwlm_pkg::CHAN_W-1:0] out_master_level
);
  import rgbwlm_pkg::*;

  // only a blocked result can push back on the input
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // a word taken with no result held raises out_valid after both registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> ##1 out_valid)
    else $error("accepted word did not reach the result register");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_front_white) &&
                                  $stable(out_master_level)))
    else $error("stalled result changed");

endmodule

bind rgb_to_rgbw_light_mapper_top rgbwlm_checker u_rgbwlm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_front_white  (out_front_white),
  .out_master_level (out_master_level)
);
